// ===== hdl/timed_pwm_run_sequencer_assert.svh =====
// assertion macros for the pwm run sequencer
// expects clk and arst_n in the scope of each use
`ifndef TIMED_PWM_RUN_SEQUENCER_ASSERT_SVH
`define TIMED_PWM_RUN_SEQUENCER_ASSERT_SVH
`ifndef SYNTHESIS
`define TPWM_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define TPWM_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define TPWM_ASSERT(label, prop, msg)
`define TPWM_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

// ===== hdl/tpwm_pkg.sv =====
// types and constants for the pwm run sequencer
// no dependencies
`default_nettype none
package tpwm_pkg;

	localparam int unsigned TIME_W = 32;
	localparam int unsigned DUTY_W = 9;
	localparam int unsigned STEP_W = 6;
	localparam int unsigned PHASE_W = 2;
	localparam int unsigned IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned IN_DATA_W = 40;
	localparam int unsigned OUT_DATA_W = 16;

	localparam logic [TIME_W-1:0] RAMP_INTERVAL_MS = 32'd10;
	localparam logic [DUTY_W-1:0] STOP_DUTY = 9'(500);

	localparam logic [PHASE_W-1:0] PH_IDLE = 2'd0;
	localparam logic [PHASE_W-1:0] PH_WAIT = 2'd1;
	localparam logic [PHASE_W-1:0] PH_RUN = 2'd2;
	localparam logic [PHASE_W-1:0] PH_STOP = 2'd3;

	localparam logic [IDX_W-1:0] REG_WAIT_TIME = 2'd0;
	localparam logic [IDX_W-1:0] REG_RUN_TIME = 2'd1;
	localparam logic [IDX_W-1:0] REG_TARGET_DUTY = 2'd2;
	localparam logic [IDX_W-1:0] REG_ACCEL_STEP = 2'd3;

	typedef struct packed {
		logic [TIME_W-1:0] wait_time_ms;
		logic [TIME_W-1:0] run_time_ms;
		logic [DUTY_W-1:0] goal_duty;
		logic [STEP_W-1:0] accel_step;
	} cfg_t;

	typedef struct packed {
		logic [PHASE_W-1:0] phase;
		logic start_pending;
		logic [TIME_W-1:0] phase_start_time;
		logic [TIME_W-1:0] last_ramp_time;
		logic [DUTY_W-1:0] ramp_duty;
		logic [DUTY_W-1:0] duty_held;
		logic work_flag;
	} seq_state_t;

	typedef struct packed {
		logic [PHASE_W-1:0] phase_now;
		logic working;
		logic duty_written;
		logic [DUTY_W-1:0] duty_out;
	} result_t;

	localparam seq_state_t STATE_RESET = '{
		phase: PH_IDLE,
		start_pending: 1'b0,
		phase_start_time: '0,
		last_ramp_time: '0,
		ramp_duty: STOP_DUTY,
		duty_held: STOP_DUTY,
		work_flag: 1'b0
	};

endpackage
`default_nettype wire

// ===== hdl/tpwm_cfg.sv =====
// configuration registers of the pwm run sequencer
// depends on tpwm_pkg
`default_nettype none
module tpwm_cfg
	import tpwm_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic we,
	input wire logic [IDX_W-1:0] index,
	input wire logic [CFG_DATA_W-1:0] data,
	output cfg_t cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wait_time_ms <= '0;
			cfg_q.run_time_ms <= '0;
			cfg_q.goal_duty <= STOP_DUTY;
			cfg_q.accel_step <= '0;
		end else if (we) begin
			case (index)
				REG_WAIT_TIME: cfg_q.wait_time_ms <= data;
				REG_RUN_TIME: cfg_q.run_time_ms <= data;
				REG_TARGET_DUTY: cfg_q.goal_duty <= data[DUTY_W-1:0];
				REG_ACCEL_STEP: cfg_q.accel_step <= data[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

// ===== hdl/tpwm_step.sv =====
// next-state and result logic for one polling word
// depends on tpwm_pkg
`default_nettype none
module tpwm_step
	import tpwm_pkg::*;
(
	input wire cfg_t cfg,
	input wire seq_state_t cur,
	input wire logic [TIME_W-1:0] now_ms,
	input wire logic start_request,
	output seq_state_t nxt,
	output result_t res
);

	logic [TIME_W-1:0] phase_elapsed;
	logic [TIME_W-1:0] ramp_elapsed;
	logic [DUTY_W-1:0] duty_gap;
	logic written;

	assign phase_elapsed = now_ms - cur.phase_start_time;
	assign ramp_elapsed = now_ms - cur.last_ramp_time;
	assign duty_gap = cur.ramp_duty - cfg.goal_duty;

	always_comb begin
		nxt = cur;
		written = 1'b0;
		nxt.start_pending = cur.start_pending | start_request;
		case (cur.phase)
			PH_IDLE: begin
				if (nxt.start_pending) begin
					nxt.start_pending = 1'b0;
					nxt.phase_start_time = now_ms;
					nxt.phase = PH_WAIT;
				end
			end
			PH_WAIT: begin
				if (phase_elapsed >= cfg.wait_time_ms) begin
					nxt.work_flag = 1'b1;
					nxt.phase_start_time = now_ms;
					nxt.last_ramp_time = now_ms;
					if (cfg.accel_step == '0) begin
						nxt.duty_held = cfg.goal_duty;
					end else begin
						nxt.ramp_duty = STOP_DUTY;
						nxt.duty_held = STOP_DUTY;
					end
					written = 1'b1;
					nxt.phase = PH_RUN;
				end
			end
			PH_RUN: begin
				if (phase_elapsed >= cfg.run_time_ms) begin
					nxt.phase = PH_STOP;
				end else if (cfg.accel_step != '0 && cur.ramp_duty > cfg.goal_duty
						&& ramp_elapsed >= RAMP_INTERVAL_MS) begin
					nxt.last_ramp_time = now_ms;
					if (duty_gap > {{(DUTY_W-STEP_W){1'b0}}, cfg.accel_step})
						nxt.ramp_duty = cur.ramp_duty
							- {{(DUTY_W-STEP_W){1'b0}}, cfg.accel_step};
					else
						nxt.ramp_duty = cfg.goal_duty;
					nxt.duty_held = nxt.ramp_duty;
					written = 1'b1;
				end
			end
			default: begin
				nxt.duty_held = STOP_DUTY;
				nxt.ramp_duty = STOP_DUTY;
				nxt.work_flag = 1'b0;
				nxt.start_pending = 1'b0;
				written = 1'b1;
				nxt.phase = PH_IDLE;
			end
		endcase
	end

	assign res.duty_out = nxt.duty_held;
	assign res.duty_written = written;
	assign res.working = nxt.work_flag;
	assign res.phase_now = nxt.phase;

endmodule
`default_nettype wire

// ===== hdl/timed_pwm_run_sequencer.sv =====
// top level of the pwm run sequencer with soft-start ramp
// depends on tpwm_pkg, tpwm_cfg, tpwm_step and timed_pwm_run_sequencer_assert.svh
//
// each input word is one polling step: the free-running millisecond time and a
// start request. every accepted word gives exactly one output word holding the
// duty compare value, a written flag, the work flag and the phase.
// the input word is captured in an input register, the step logic runs between
// that register and the output register; m_tvalid rises once the word has passed
// both registers; one word per cycle goes back to back while m_tready is high.
// when the receiver holds m_tready low the output register keeps its word, the
// input register fills and s_tready then drops until the output word is taken.
// configuration writes go through cfg_we/cfg_index/cfg_data and take effect at
// the next edge; write them only while no word is in flight.
// reset clears the phase to idle, the flags and time stamps to zero, the duty
// to the stop value 500 and the registers to 0, 0, 500, 0.
`default_nettype none
`include "timed_pwm_run_sequencer_assert.svh"
module timed_pwm_run_sequencer
	import tpwm_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [IDX_W-1:0] cfg_index,
	input wire logic [CFG_DATA_W-1:0] cfg_data,
	input wire logic s_tvalid,
	output logic s_tready,
	// now_ms[31:0], start_request[32], zero[39:33]
	input wire logic [IN_DATA_W-1:0] s_tdata,
	output logic m_tvalid,
	input wire logic m_tready,
	// duty_out[8:0], duty_written[9], working[10], phase_now[12:11], zero[15:13]
	output logic [OUT_DATA_W-1:0] m_tdata
);

	cfg_t cfg;
	seq_state_t st_q;
	seq_state_t st_next;
	result_t res;
	result_t res_q;
	logic valid_s1;
	logic [TIME_W-1:0] now_s1;
	logic start_s1;
	logic out_valid_q;
	logic adv;

	tpwm_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.we(cfg_we),
		.index(cfg_index),
		.data(cfg_data),
		.cfg(cfg)
	);

	tpwm_step u_step (
		.cfg(cfg),
		.cur(st_q),
		.now_ms(now_s1),
		.start_request(start_s1),
		.nxt(st_next),
		.res(res)
	);

	assign adv = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
			st_q <= STATE_RESET;
		end else begin
			if (s_tready)
				valid_s1 <= s_tvalid;
			if (adv) begin
				st_q <= st_next;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			now_s1 <= s_tdata[TIME_W-1:0];
			start_s1 <= s_tdata[TIME_W];
		end
		if (adv)
			res_q <= res;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {{(OUT_DATA_W-$bits(result_t)){1'b0}}, res_q};

	`TPWM_ASSERT(a_work_matches_phase, st_q.work_flag == st_q.phase[1], "work flag out of step with phase")
	`TPWM_ASSERT(a_ramp_bounded, st_q.ramp_duty <= STOP_DUTY, "ramp duty above stop duty")
	`TPWM_ASSERT(a_commit_gives_word, adv |=> out_valid_q, "committed step produced no output word")
	`TPWM_ASSERT(a_phase_holds, !adv |=> $stable(st_q.phase), "phase moved without a committed step")

endmodule
`default_nettype wire
